[rtl/bfa_pkg.sv]
// Shared constants and types of the bitmap frame allocator.
// No dependencies; every other file of the block but bfa_ram imports this package.
package bfa_pkg;

    // Sizing of the frame map and of the address space.
    localparam int MAX_FRAMES  = 65536;
    localparam int FRAME_SHIFT = 12;
    localparam int ADDR_BITS   = 48;

    // Fixed field widths of the channels.
    localparam int CMD_BITS   = 2;
    localparam int COUNT_BITS = 17;
    localparam int CFG_BITS   = 17;
    localparam int CTR_BITS   = 32;

    // The bitmap is stored as words of WORD_BITS frames each.
    localparam int WORD_BITS  = 32;
    localparam int OFF_BITS   = $clog2(WORD_BITS);
    localparam int NB_BITS    = OFF_BITS + 1;
    localparam int WORDS      = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_BITS = (WORDS > 1) ? $clog2(WORDS) : 1;

    // Frame index of a full address, and the search pointer width.
    localparam int FIDX_BITS    = ADDR_BITS - FRAME_SHIFT;
    localparam int PTR_RAW_BITS = $clog2(MAX_FRAMES + 1);
    localparam int PTR_BITS     = (PTR_RAW_BITS > NB_BITS) ? PTR_RAW_BITS : NB_BITS;
    localparam int LIM_CMP_BITS = (PTR_BITS > CFG_BITS) ? PTR_BITS : CFG_BITS;

    // Reset value of the frame count register.
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(65536);

    typedef logic [FIDX_BITS-1:0]  frame_idx_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [NB_BITS-1:0]    nbits_t;
    typedef logic [PTR_BITS-1:0]   ptr_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [CTR_BITS-1:0]   ctr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // Command codes of the request channel.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_MARK    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TEST    = 2'd2,
        CMD_REQUEST = 2'd3
    } cmd_t;

endpackage

[rtl/bfa_if.sv]
// Handshake channels of the bitmap frame allocator: request, response, config.
// Depends on bfa_pkg for the field widths.

// Request channel: one command item.
interface bfa_req_if import bfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   command;
    logic [ADDR_BITS-1:0]  address;
    logic [COUNT_BITS-1:0] count;

    modport source (output valid, command, address, count, input ready);
    modport sink   (input valid, command, address, count, output ready);
endinterface

// Response channel: one result item per command.
interface bfa_rsp_if import bfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] alloc_address;
    logic                 frame_used;
    logic                 out_of_memory;
    logic [CTR_BITS-1:0]  used_frames;
    logic [CTR_BITS-1:0]  free_total;

    modport source (output valid, alloc_address, frame_used, out_of_memory,
                     used_frames, free_total, input ready);
    modport sink   (input valid, alloc_address, frame_used, out_of_memory,
                     used_frames, free_total, output ready);
endinterface

// Configuration channel: writes the frame count register.
interface bfa_cfg_if import bfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] frames_in_use;

    modport source (output valid, frames_in_use, input ready);
    modport sink   (input valid, frames_in_use, output ready);
endinterface

[rtl/bfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/bitmap_frame_allocator_core.sv]
// Top level of the bitmap frame allocator: sequencer, counters and result register.
// Depends on bfa_pkg, the channel interfaces in bfa_if and the bitmap RAM bfa_ram.
//
//  channel | modport | moves                                        | handshake
//  --------+---------+----------------------------------------------+------------
//  req     | sink    | command, address, count                      | valid/ready
//  rsp     | source  | alloc_address, frame_used, out_of_memory,    | valid/ready
//          |         | used_frames, free_total                      |
//  cfg     | sink    | frames_in_use                                | valid/ready
//
// One item is worked on at a time; each touches the bitmap RAM one 32-frame word at a
// time. A mark, a release and the run of a request read a word and write it back in the
// next cycle; a test only reads. A request scans a word that is all used or all free as
// a whole and a mixed word frame by frame, then marks its run like a release. After
// reset a fill pass writes every word as used, with req.ready low. A finished result
// waits in the output register; the next item is taken meanwhile.
module bitmap_frame_allocator_core import bfa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bfa_req_if.sink   req,
    bfa_rsp_if.source rsp,
    bfa_cfg_if.sink   cfg
);

    typedef enum logic [9:0] {
        S_INIT      = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_RUN_RD    = 10'b00_0000_0100,
        S_RUN_WR    = 10'b00_0000_1000,
        S_TEST_RD   = 10'b00_0001_0000,
        S_TEST_EV   = 10'b00_0010_0000,
        S_SCAN_RD   = 10'b00_0100_0000,
        S_SCAN_WORD = 10'b00_1000_0000,
        S_SCAN_BIT  = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    // Mask of the low k bits of a word.
    function automatic word_t low_mask(input nbits_t k);
        word_t m;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            m[b] = (NB_BITS'(b) < k);
        end
        return m;
    endfunction

    // Number of frames of the word holding idx that lie below lim.
    function automatic nbits_t word_limit(input frame_idx_t idx, input frame_idx_t lim);
        frame_idx_t wbase;
        frame_idx_t diff;
        wbase = idx & ~frame_idx_t'(WORD_BITS - 1);
        diff  = lim - wbase;
        if (wbase >= lim)
        begin
            return '0;
        end
        else if (diff >= frame_idx_t'(WORD_BITS))
        begin
            return NB_BITS'(WORD_BITS);
        end
        else
        begin
            return NB_BITS'(diff);
        end
    endfunction

    state_t                 state_reg, state_next;
    logic [WADDR_BITS-1:0]  init_cnt_reg, init_cnt_next;
    logic [CFG_BITS-1:0]    cfg_reg, cfg_next;
    ptr_t                   sp_reg, sp_next;
    ctr_t                   used_ctr_reg, used_ctr_next;
    ctr_t                   free_ctr_reg, free_ctr_next;
    frame_idx_t             f_reg, f_next;
    count_t                 r_reg, r_next;
    logic                   set_reg, set_next;
    count_t                 run_reg, run_next;
    ptr_t                   start_reg, start_next;
    word_t                  word_reg, word_next;
    addr_t                  res_alloc_reg, res_alloc_next;
    logic                   res_tested_reg, res_tested_next;
    logic                   res_oom_reg, res_oom_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    addr_t                  out_alloc_reg, out_alloc_next;
    logic                   out_tested_reg, out_tested_next;
    logic                   out_oom_reg, out_oom_next;
    ctr_t                   out_used_reg, out_used_next;
    ctr_t                   out_free_reg, out_free_next;

    // RAM ports.
    logic                  ram_we;
    logic [WADDR_BITS-1:0] ram_waddr;
    word_t                 ram_wdata;
    logic                  ram_re;
    logic [WADDR_BITS-1:0] ram_raddr;
    word_t                 ram_rdata;

    // Effective frame limit.
    logic [LIM_CMP_BITS-1:0] cfg_wide;
    ptr_t                    limit;
    frame_idx_t              lim_f;

    // Read-modify-write of one word of a run.
    logic [OFF_BITS-1:0] run_off;
    nbits_t              run_off_ext;
    nbits_t              run_room;
    nbits_t              run_n;
    nbits_t              run_end;
    nbits_t              run_lh;
    word_t               run_eff;
    nbits_t              run_cnt;
    word_t               run_wdata;

    // Scan of one word from the search pointer.
    frame_idx_t            sp_f;
    logic [OFF_BITS-1:0]   sc_off;
    nbits_t                sc_off_ext;
    nbits_t                sc_lh;
    nbits_t                sc_nb;
    word_t                 sc_range;
    word_t                 sc_free;
    ptr_t                  sc_start;
    logic [COUNT_BITS:0]   sc_sum;
    logic                  sc_hit;
    nbits_t                sc_need;
    ptr_t                  sc_found_ptr;
    ptr_t                  sc_adv;
    logic                  bit_free;
    ptr_t                  bit_next;

    logic                  slot_free;
    logic                  in_range;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Frame limit: the register, capped at the map size.
    assign cfg_wide = LIM_CMP_BITS'(cfg_reg);
    assign limit    = (cfg_wide > LIM_CMP_BITS'(MAX_FRAMES)) ? PTR_BITS'(MAX_FRAMES)
                                                             : PTR_BITS'(cfg_wide);
    assign lim_f    = FIDX_BITS'(limit);

    // Word update of a run: frames f_reg onward, up to the end of the run or of the word.
    always_comb
    begin
        run_off     = f_reg[OFF_BITS-1:0];
        run_off_ext = {1'b0, run_off};
        run_room    = NB_BITS'(WORD_BITS) - run_off_ext;
        run_n       = (r_reg < COUNT_BITS'(run_room)) ? NB_BITS'(r_reg) : run_room;
        run_end     = run_off_ext + run_n;
        run_lh      = word_limit(f_reg, lim_f);
        run_eff     = low_mask(run_end) & ~low_mask(run_off_ext) & low_mask(run_lh);
        if (run_end <= run_lh)
        begin
            run_cnt = run_n;
        end
        else if (run_lh > run_off_ext)
        begin
            run_cnt = run_lh - run_off_ext;
        end
        else
        begin
            run_cnt = '0;
        end
        run_wdata = set_reg ? (ram_rdata | run_eff) : (ram_rdata & ~run_eff);
    end

    // Word scan from the search pointer to the end of its word or the limit.
    always_comb
    begin
        sp_f         = FIDX_BITS'(sp_reg);
        sc_off       = sp_reg[OFF_BITS-1:0];
        sc_off_ext   = {1'b0, sc_off};
        sc_lh        = word_limit(sp_f, lim_f);
        sc_nb        = sc_lh - sc_off_ext;
        sc_range     = low_mask(sc_lh) & ~low_mask(sc_off_ext);
        sc_free      = ~ram_rdata & sc_range;
        sc_start     = (run_reg == '0) ? sp_reg : start_reg;
        sc_sum       = {1'b0, run_reg} + (COUNT_BITS + 1)'(sc_nb);
        sc_hit       = (sc_sum >= {1'b0, r_reg});
        sc_need      = NB_BITS'(r_reg - run_reg);
        sc_found_ptr = sp_reg + PTR_BITS'(sc_need) - PTR_BITS'(1);
        sc_adv       = sp_reg + PTR_BITS'(sc_nb);
        bit_free     = ~word_reg[sc_off];
        bit_next     = sp_reg + PTR_BITS'(1);
    end

    // RAM access: the fill pass, the run word, or the scan word.
    always_comb
    begin
        ram_we    = (state_reg == S_INIT) || ((state_reg == S_RUN_WR) && (run_eff != '0));
        ram_waddr = (state_reg == S_INIT) ? init_cnt_reg : f_reg[OFF_BITS +: WADDR_BITS];
        ram_wdata = (state_reg == S_INIT) ? '1 : run_wdata;
        ram_re    = (state_reg == S_RUN_RD) || (state_reg == S_TEST_RD)
                 || (state_reg == S_SCAN_RD);
        ram_raddr = (state_reg == S_SCAN_RD) ? sp_f[OFF_BITS +: WADDR_BITS]
                                             : f_reg[OFF_BITS +: WADDR_BITS];
    end

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign in_range  = (f_reg < lim_f);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        cfg_next        = cfg_reg;
        sp_next         = sp_reg;
        used_ctr_next   = used_ctr_reg;
        free_ctr_next   = free_ctr_reg;
        f_next          = f_reg;
        r_next          = r_reg;
        set_next        = set_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        word_next       = word_reg;
        res_alloc_next  = res_alloc_reg;
        res_tested_next = res_tested_reg;
        res_oom_next    = res_oom_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_alloc_next  = out_alloc_reg;
        out_tested_next = out_tested_reg;
        out_oom_next    = out_oom_reg;
        out_used_next   = out_used_reg;
        out_free_next   = out_free_reg;

        // Configuration writes are taken in every state.
        if (cfg.valid)
        begin
            cfg_next = cfg.frames_in_use;
        end

        case (state_reg)
            // Fill every word of the map as used.
            S_INIT:
            begin
                init_cnt_next = init_cnt_reg + WADDR_BITS'(1);
                if (init_cnt_reg == WADDR_BITS'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a command item.
            S_IDLE:
            begin
                if (req.valid)
                begin
                    f_next          = req.address[ADDR_BITS-1:FRAME_SHIFT];
                    r_next          = req.count;
                    run_next        = '0;
                    res_alloc_next  = '0;
                    res_tested_next = 1'b0;
                    res_oom_next    = 1'b0;
                    case (req.command)
                        CMD_MARK:
                        begin
                            r_next     = COUNT_BITS'(1);
                            set_next   = 1'b1;
                            state_next = S_RUN_RD;
                        end
                        CMD_RELEASE:
                        begin
                            set_next   = 1'b0;
                            state_next = (req.count == '0) ? S_DONE : S_RUN_RD;
                        end
                        CMD_TEST:
                        begin
                            state_next = S_TEST_RD;
                        end
                        CMD_REQUEST:
                        begin
                            if (req.count == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else if (sp_reg >= limit)
                            begin
                                res_oom_next = 1'b1;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RUN_RD:
            begin
                state_next = S_RUN_WR;
            end

            // Write back one word of the run and move the counters.
            S_RUN_WR:
            begin
                if (set_reg)
                begin
                    used_ctr_next = used_ctr_reg + CTR_BITS'(run_cnt);
                    free_ctr_next = free_ctr_reg - CTR_BITS'(run_cnt);
                end
                else
                begin
                    used_ctr_next = used_ctr_reg - CTR_BITS'(run_cnt);
                    free_ctr_next = free_ctr_reg + CTR_BITS'(run_cnt);
                end
                f_next = f_reg + FIDX_BITS'(run_n);
                r_next = r_reg - COUNT_BITS'(run_n);
                state_next = (r_reg == COUNT_BITS'(run_n)) ? S_DONE : S_RUN_RD;
            end

            S_TEST_RD:
            begin
                state_next = S_TEST_EV;
            end

            S_TEST_EV:
            begin
                res_tested_next = in_range && ram_rdata[f_reg[OFF_BITS-1:0]];
                state_next      = S_DONE;
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_WORD;
            end

            // Whole-word scan step; a mixed word falls back to one frame a cycle.
            S_SCAN_WORD:
            begin
                if (sc_free == '0)
                begin
                    run_next = '0;
                    sp_next  = sc_adv;
                    if (sc_adv >= limit)
                    begin
                        res_oom_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if (sc_free == sc_range)
                begin
                    start_next = sc_start;
                    if (sc_hit)
                    begin
                        sp_next        = sc_found_ptr;
                        f_next         = FIDX_BITS'(sc_start);
                        set_next       = 1'b1;
                        res_alloc_next = addr_t'(sc_start) << FRAME_SHIFT;
                        state_next     = S_RUN_RD;
                    end
                    else
                    begin
                        run_next = COUNT_BITS'(sc_sum);
                        sp_next  = sc_adv;
                        if (sc_adv >= limit)
                        begin
                            res_oom_next = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                end
                else
                begin
                    word_next  = ram_rdata;
                    state_next = S_SCAN_BIT;
                end
            end

            // One frame of a mixed word.
            S_SCAN_BIT:
            begin
                if (bit_free && (run_reg + COUNT_BITS'(1) == r_reg))
                begin
                    f_next         = FIDX_BITS'(sc_start);
                    set_next       = 1'b1;
                    res_alloc_next = addr_t'(sc_start) << FRAME_SHIFT;
                    state_next     = S_RUN_RD;
                end
                else
                begin
                    if (bit_free)
                    begin
                        start_next = sc_start;
                        run_next   = run_reg + COUNT_BITS'(1);
                    end
                    else
                    begin
                        run_next = '0;
                    end
                    sp_next = bit_next;
                    if (bit_next >= limit)
                    begin
                        res_oom_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (bit_next[OFF_BITS-1:0] == '0)
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    out_alloc_next  = res_alloc_reg;
                    out_tested_next = res_tested_reg;
                    out_oom_next    = res_oom_reg;
                    out_used_next   = used_ctr_reg;
                    out_free_next   = free_ctr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            cfg_reg       <= CFG_RESET;
            sp_reg        <= '0;
            used_ctr_reg  <= '0;
            free_ctr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            cfg_reg       <= cfg_next;
            sp_reg        <= sp_next;
            used_ctr_reg  <= used_ctr_next;
            free_ctr_reg  <= free_ctr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        f_reg          <= f_next;
        r_reg          <= r_next;
        set_reg        <= set_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        word_reg       <= word_next;
        res_alloc_reg  <= res_alloc_next;
        res_tested_reg <= res_tested_next;
        res_oom_reg    <= res_oom_next;
        out_alloc_reg  <= out_alloc_next;
        out_tested_reg <= out_tested_next;
        out_oom_reg    <= out_oom_next;
        out_used_reg   <= out_used_next;
        out_free_reg   <= out_free_next;
    end

    // Channel outputs.
    assign req.ready         = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.alloc_address = out_alloc_reg;
    assign rsp.frame_used    = out_tested_reg;
    assign rsp.out_of_memory = out_oom_reg;
    assign rsp.used_frames   = out_used_reg;
    assign rsp.free_total    = out_free_reg;

endmodule

[tb/bfa_result_check.sv]
`timescale 1ns / 100ps
// Result checker of the bitmap frame allocator: it watches the three channels, keeps
// its own frame map, search pointer and counters, and compares every result item.
// Depends on bfa_pkg and the channel interfaces in bfa_if.
module bfa_result_check import bfa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bfa_req_if   req,
    bfa_rsp_if   rsp,
    bfa_cfg_if   cfg,
    output int   fail_count,
    output int   outstanding
);

    // One predicted result item.
    typedef struct {
        addr_t alloc_address;
        logic  frame_used;
        logic  out_of_memory;
        ctr_t  used_frames;
        ctr_t  free_total;
    } frame_outcome_t;

    // Predicted allocator state: one bit per frame, set while the frame is used.
    bit [MAX_FRAMES-1:0] used_map;
    int unsigned         scan_ptr;
    ctr_t                used_ctr;
    ctr_t                free_ctr;
    logic [CFG_BITS-1:0] frame_count;

    frame_outcome_t outcome_q[$];
    frame_outcome_t want;

    // Frames above MAX_FRAMES do not exist, whatever the register says.
    function automatic int unsigned tracked_frames();
        if (frame_count > MAX_FRAMES)
        begin
            return MAX_FRAMES;
        end
        return int'(frame_count);
    endfunction

    // Sets or clears one frame; the counters move even when the bit already had that value.
    function automatic void set_frame(longint unsigned idx, bit used);
        if (idx < tracked_frames())
        begin
            used_map[int'(idx)] = used;
            if (used)
            begin
                used_ctr = used_ctr + 1'b1;
                free_ctr = free_ctr - 1'b1;
            end
            else
            begin
                used_ctr = used_ctr - 1'b1;
                free_ctr = free_ctr + 1'b1;
            end
        end
    endfunction

    // Applies one command to the predicted state and returns the result it should give.
    function automatic frame_outcome_t apply_command(cmd_t op, addr_t addr, count_t count);
        frame_outcome_t  res;
        longint unsigned idx;
        int unsigned     limit;
        int unsigned     start;
        int unsigned     run_len;
        int unsigned     i;
        bit              found;
        addr_t           frame_addr;
        res = '{alloc_address: '0, frame_used: 1'b0, out_of_memory: 1'b0,
                used_frames: '0, free_total: '0};
        limit = tracked_frames();
        case (op)
            CMD_MARK:
            begin
                set_frame(addr >> FRAME_SHIFT, 1'b1);
            end
            CMD_RELEASE:
            begin
                // Frame addresses of a run wrap around the top of the address space.
                for (i = 0; i < count; i++)
                begin
                    frame_addr = addr + (addr_t'(i) << FRAME_SHIFT);
                    set_frame(frame_addr >> FRAME_SHIFT, 1'b0);
                end
            end
            CMD_TEST:
            begin
                idx = addr >> FRAME_SHIFT;
                if (idx < limit)
                begin
                    res.frame_used = used_map[int'(idx)];
                end
            end
            CMD_REQUEST:
            begin
                // Next-fit scan; the pointer stops on the last frame of a run it finds.
                if (count != 0)
                begin
                    run_len = 0;
                    start   = 0;
                    found   = 1'b0;
                    while (scan_ptr < limit && !found)
                    begin
                        if (!used_map[scan_ptr])
                        begin
                            if (run_len == 0)
                            begin
                                start = scan_ptr;
                            end
                            run_len++;
                            found = (run_len == count);
                        end
                        else
                        begin
                            run_len = 0;
                        end
                        if (!found)
                        begin
                            scan_ptr++;
                        end
                    end
                    if (found)
                    begin
                        for (i = 0; i < count; i++)
                        begin
                            set_frame(start + i, 1'b1);
                        end
                        res.alloc_address = addr_t'(start) << FRAME_SHIFT;
                    end
                    else
                    begin
                        res.out_of_memory = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.used_frames = used_ctr;
        res.free_total  = free_ctr;
        return res;
    endfunction

    function automatic void compare_field(string field, logic [63:0] exp_val,
                                          logic [63:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, got_val);
            fail_count++;
        end
    endfunction

    // Results are taken before new items, so a result never meets the item of its own edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_map    = '1;
            scan_ptr    = 0;
            used_ctr    = '0;
            free_ctr    = '0;
            frame_count = CFG_RESET;
            outcome_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result item arrived with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    compare_field("alloc_address", want.alloc_address, rsp.alloc_address);
                    compare_field("frame_used", want.frame_used, rsp.frame_used);
                    compare_field("out_of_memory", want.out_of_memory, rsp.out_of_memory);
                    compare_field("used_frames", want.used_frames, rsp.used_frames);
                    compare_field("free_total", want.free_total, rsp.free_total);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                frame_count = cfg.frames_in_use;
            end
            if (req.valid && req.ready)
            begin
                outcome_q.push_back(apply_command(cmd_t'(req.command), req.address,
                                                  req.count));
            end
            outstanding = outcome_q.size();
        end
    end

endmodule

[tb/bitmap_frame_allocator_core_tb.sv]
`timescale 1ns / 100ps
// Top of the bitmap frame allocator testbench: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, the channel interfaces in bfa_if, the core and bfa_result_check.
module bitmap_frame_allocator_core_tb import bfa_pkg::*; ();

    localparam int ITEM_TARGET   = 1050;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int HOLD_CYCLES   = 500;
    localparam int REGION_CEIL   = 64000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();
    bfa_cfg_if cfg_ch();

    int          fail_count;
    int          outstanding;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    // First frame not yet handed out as a free region.
    int unsigned frontier    = 32;

    bitmap_frame_allocator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bfa_result_check alloc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // A stretch of items in the middle of the run goes without any idling.
    function automatic bit idle_now();
        if (items_sent >= 600 && items_sent < 760)
        begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic addr_t frame_address(int unsigned frame);
        return (addr_t'(frame) << FRAME_SHIFT) |
               addr_t'($urandom_range(0, (1 << FRAME_SHIFT) - 1));
    endfunction

    function automatic addr_t any_address();
        return addr_t'({$urandom(), $urandom()});
    endfunction

    // Response side: random stalls, plus one long hold-off once the run is well under way.
    always @(negedge clk)
    begin
        if (!hold_done && items_sent >= HOLD_AT_ITEM)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= !idle_now();
        end
    end

    // Offers one command item and returns at the falling edge after it was taken.
    task automatic send_item(cmd_t op, addr_t addr, count_t n);
        while (idle_now())
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= op;
        req_ch.address <= addr;
        req_ch.count   <= n;
        items_sent++;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Stops offering items until every outstanding result has come back.
    task automatic wait_drained(int settle);
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_frame_count(logic [CFG_BITS-1:0] value);
        wait_drained(SETTLE_CYCLES);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.frames_in_use <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Background items; marks keep out of [keep_lo, keep_hi) so a run being handed out
    // stays whole.
    task automatic send_noise(int unsigned keep_lo, int unsigned keep_hi);
        int unsigned frame;
        frame = $urandom_range(0, MAX_FRAMES - 1);
        case ($urandom_range(0, 9))
            0, 1: send_item(CMD_TEST, frame_address(frame), count_t'($urandom()));
            2:    send_item(CMD_TEST, any_address(), count_t'($urandom()));
            3, 4:
            begin
                if (frame >= keep_lo && frame < keep_hi)
                begin
                    send_item(CMD_MARK, any_address(), count_t'($urandom()));
                end
                else
                begin
                    send_item(CMD_MARK, frame_address(frame), count_t'($urandom()));
                end
            end
            5, 6: send_item(CMD_RELEASE, frame_address($urandom_range(0, keep_lo)),
                            count_t'($urandom_range(1, 8)));
            7:
            begin
                // Now and then a release whose count can reach MAX_FRAMES.
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(CMD_RELEASE, any_address(),
                              count_t'($urandom_range(0, MAX_FRAMES)));
                end
                else
                begin
                    send_item(CMD_RELEASE, any_address(), count_t'($urandom_range(0, 64)));
                end
            end
            8:    send_item(CMD_REQUEST, any_address(), '0);
            default: send_item(CMD_TEST, frame_address(keep_lo + $urandom_range(0, 3)), '0);
        endcase
    endtask

    // Frees a fresh region above the frontier and claims it with small requests.
    task automatic run_region();
        int unsigned base;
        int unsigned span;
        int unsigned left;
        int unsigned n;
        base     = frontier + $urandom_range(0, 40);
        span     = $urandom_range(8, 96);
        frontier = base + span;
        send_item(CMD_RELEASE, frame_address(base), count_t'(span));
        left = span;
        // Once in a while the region is released and then left alone.
        if ($urandom_range(0, 9) == 0)
        begin
            left = 0;
        end
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 40)
            begin
                send_noise(base, frontier);
            end
            n = $urandom_range(1, (left < 24) ? left : 24);
            send_item(CMD_REQUEST, any_address(), count_t'(n));
            left -= n;
        end
    endtask

    // Runs a few items under a reduced frame count, then restores a full one.
    task automatic run_limit_phase();
        int unsigned tight;
        case ($urandom_range(0, 2))
            0:
            begin
                // Nothing is tracked at all.
                write_frame_count('0);
                repeat (4) send_noise(0, 0);
                send_item(CMD_REQUEST, any_address(), count_t'($urandom_range(1, MAX_FRAMES)));
            end
            1:
            begin
                // A small map that ends below the search pointer.
                write_frame_count(CFG_BITS'($urandom_range(1, 48)));
                send_item(CMD_TEST, frame_address($urandom_range(0, 47)), '0);
                send_item(CMD_RELEASE, frame_address($urandom_range(0, 40)),
                          count_t'($urandom_range(1, 16)));
                send_item(CMD_TEST, frame_address($urandom_range(0, 47)), '0);
                send_item(CMD_MARK, frame_address($urandom_range(0, 47)), '0);
                send_item(CMD_REQUEST, any_address(), count_t'($urandom_range(1, 200)));
            end
            default:
            begin
                // The map ends just past the frontier: a long request fails and leaves
                // the pointer at the end of the map.
                if (frontier + 41 < MAX_FRAMES)
                begin
                    tight = frontier + $urandom_range(1, 40);
                    write_frame_count(CFG_BITS'(tight));
                    send_item(CMD_REQUEST, any_address(),
                              count_t'($urandom_range(1000, MAX_FRAMES)));
                    send_item(CMD_TEST, frame_address(tight), '0);
                    frontier = tight + 1;
                end
            end
        endcase
        case ($urandom_range(0, 3))
            0:       write_frame_count(CFG_BITS'(MAX_FRAMES));
            1:       write_frame_count(CFG_BITS'(MAX_FRAMES + 1));
            2:       write_frame_count('1);
            default: write_frame_count(CFG_BITS'(100000));
        endcase
    endtask

    task automatic run_directed();
        addr_t top_addr;
        top_addr = '1;
        // The map comes out of reset with every frame used.
        send_item(CMD_TEST, frame_address(0), '0);
        send_item(CMD_TEST, top_addr, '1);
        // Marking a used frame still moves the counters; free wraps below zero.
        send_item(CMD_MARK, frame_address(5), '0);
        send_item(CMD_MARK, top_addr, '0);
        send_item(CMD_RELEASE, frame_address(0), '0);
        send_item(CMD_RELEASE, frame_address(0), count_t'(16));
        send_item(CMD_TEST, frame_address(3), '0);
        // Zero-length request, then runs that use up the freed frames exactly.
        send_item(CMD_REQUEST, any_address(), '0);
        send_item(CMD_REQUEST, '0, count_t'(1));
        send_item(CMD_REQUEST, top_addr, count_t'(4));
        send_item(CMD_REQUEST, '0, count_t'(11));
        // A release at the top of the address space wraps around to frames 0 and 1.
        send_item(CMD_RELEASE, {{(ADDR_BITS - FRAME_SHIFT){1'b1}},
                                FRAME_SHIFT'($urandom())}, count_t'(3));
        send_item(CMD_TEST, frame_address(1), '0);
        // Last frame of the map and the first one past it.
        send_item(CMD_RELEASE, frame_address(MAX_FRAMES - 1), count_t'(2));
        send_item(CMD_TEST, frame_address(MAX_FRAMES - 1), '0);
        send_item(CMD_TEST, frame_address(MAX_FRAMES), '0);
        send_item(CMD_MARK, frame_address(MAX_FRAMES - 1), '0);
        send_item(CMD_MARK, frame_address(MAX_FRAMES), '0);
        // A count of MAX_FRAMES, mostly past the end of the map.
        send_item(CMD_RELEASE, frame_address(65000), count_t'(MAX_FRAMES));
        send_item(CMD_TEST, frame_address(65100), '0);
    endtask

    task automatic run_random();
        int next_phase;
        next_phase = items_sent + 120;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_phase)
            begin
                run_limit_phase();
                next_phase = items_sent + 120;
            end
            else if (frontier + 140 < REGION_CEIL && $urandom_range(0, 99) < 85)
            begin
                run_region();
            end
            else
            begin
                send_noise(frontier, frontier);
            end
        end
    endtask

    // A request that cannot fit pushes the pointer to the end, and it never comes back.
    task automatic run_closing();
        write_frame_count(CFG_BITS'(MAX_FRAMES));
        send_item(CMD_REQUEST, any_address(), count_t'(MAX_FRAMES));
        send_item(CMD_REQUEST, any_address(), count_t'(1));
        send_item(CMD_RELEASE, '0, count_t'(MAX_FRAMES));
        send_item(CMD_REQUEST, any_address(), count_t'(1));
        send_item(CMD_TEST, frame_address(70), '0);
    endtask

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_MARK;
        req_ch.address       = '0;
        req_ch.count         = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.frames_in_use = CFG_RESET;
        rsp_ch.ready         = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();
        run_closing();
        wait_drained(SETTLE_CYCLES);

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
